[src/c02dec_pkg.sv]
// Shared types and decode tables for the 65C02 opcode decoder.
// No dependencies; used by c02dec_decode, c02dec_operand and the top level.

package c02dec_pkg;

	// Addressing modes
	typedef enum logic [3:0] {
		AM_NONE = 4'd0,
		AM_IMM  = 4'd1,
		AM_ZP   = 4'd2,
		AM_ZPX  = 4'd3,
		AM_ZPY  = 4'd4,
		AM_ABS  = 4'd5,
		AM_ABX  = 4'd6,
		AM_ABY  = 4'd7,
		AM_IDX  = 4'd8,
		AM_IDY  = 4'd9,
		AM_JMP  = 4'd10,
		AM_JSR  = 4'd11,
		AM_REL  = 4'd12,
		AM_INV  = 4'd13,
		AM_ZPI  = 4'd14
	} addr_mode_t;

	// Mnemonic codes; the X prefix marks the undocumented forms
	typedef enum logic [6:0] {
		MN_BRK, MN_PHP, MN_BPL, MN_CLC, MN_XNOP, MN_JSR, MN_PLP, MN_BMI,
		MN_SEC, MN_BIT, MN_RTI, MN_PHA, MN_JMP, MN_BVC, MN_CLI, MN_RTS,
		MN_PLA, MN_BVS, MN_SEI, MN_DEY, MN_BCC, MN_TYA, MN_STY, MN_TAY,
		MN_BCS, MN_CLV, MN_LDY, MN_INY, MN_BNE, MN_CLD, MN_CPY, MN_INX,
		MN_BEQ, MN_SED, MN_CPX, MN_ORA, MN_AND, MN_EOR, MN_ADC, MN_STA,
		MN_LDA, MN_CMP, MN_SBC, MN_ASL, MN_ROL, MN_PHY, MN_LSR, MN_PLY,
		MN_ROR, MN_TXA, MN_TXS, MN_STX, MN_TAX, MN_TSX, MN_LDX, MN_DEX,
		MN_PHX, MN_DEC, MN_NOP, MN_PLX, MN_INC, MN_XSLO, MN_XRLA, MN_XSRE,
		MN_XRRA, MN_XSAX, MN_XLAX, MN_XDCP, MN_XSBC, MN_XISB
	} mnemonic_t;

	// Table-decoded part of one instruction
	typedef struct packed {
		mnemonic_t  mnemonic;
		addr_mode_t mode;
		logic       indirect;
	} dec_t;

	// Complete result of one instruction
	typedef struct packed {
		dec_t        dec;
		logic [15:0] operand;
		logic [1:0]  length;
		logic [15:0] next_pc;
		logic [15:0] branch_target;
	} res_t;

	// Byte field positions: aaa bbb cc
	localparam logic [1:0] CC_GROUP0 = 2'd0;
	localparam logic [2:0] AAA_JMP   = 3'd3;
	localparam logic [2:0] AAA_STA   = 3'd4;
	localparam logic [2:0] AAA_SBC   = 3'd7;
	localparam logic [2:0] BBB_IMM   = 3'd2;
	localparam logic [2:0] BBB_ABS   = 3'd3;

	// Mode table, indexed [cc][bbb][aaa]
	localparam addr_mode_t MODE_TAB [4][8][8] = '{
		'{
			'{AM_NONE, AM_JSR, AM_NONE, AM_NONE, AM_IMM, AM_IMM, AM_IMM, AM_IMM},
			'{AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP},
			'{AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE},
			'{AM_ABS, AM_ABS, AM_JMP, AM_JMP, AM_ABS, AM_ABS, AM_ABS, AM_ABS},
			'{AM_REL, AM_REL, AM_REL, AM_REL, AM_REL, AM_REL, AM_REL, AM_REL},
			'{AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX},
			'{AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE},
			'{AM_ABX, AM_ABX, AM_ABS, AM_ABS, AM_INV, AM_ABX, AM_ABX, AM_ABX}
		},
		'{
			'{AM_IDX, AM_IDX, AM_IDX, AM_IDX, AM_IDX, AM_IDX, AM_IDX, AM_IDX},
			'{AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP},
			'{AM_IMM, AM_IMM, AM_IMM, AM_IMM, AM_IMM, AM_IMM, AM_IMM, AM_IMM},
			'{AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS},
			'{AM_IDY, AM_IDY, AM_IDY, AM_IDY, AM_IDY, AM_IDY, AM_IDY, AM_IDY},
			'{AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX},
			'{AM_ABY, AM_ABY, AM_ABY, AM_ABY, AM_ABY, AM_ABY, AM_ABY, AM_ABY},
			'{AM_ABX, AM_ABX, AM_ABX, AM_ABX, AM_ABX, AM_ABX, AM_ABX, AM_ABX}
		},
		'{
			'{AM_INV, AM_INV, AM_INV, AM_INV, AM_IMM, AM_IMM, AM_IMM, AM_IMM},
			'{AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP},
			'{AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE},
			'{AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS},
			'{AM_INV, AM_INV, AM_INV, AM_INV, AM_INV, AM_ZPI, AM_INV, AM_INV},
			'{AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPY, AM_ZPY, AM_ZPX, AM_ZPX},
			'{AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE, AM_NONE},
			'{AM_ABX, AM_ABX, AM_ABX, AM_ABX, AM_INV, AM_ABY, AM_ABX, AM_ABX}
		},
		'{
			'{AM_IDX, AM_IDX, AM_IDX, AM_IDX, AM_IDX, AM_IDX, AM_IDX, AM_IDX},
			'{AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP, AM_ZP},
			'{AM_INV, AM_INV, AM_INV, AM_INV, AM_INV, AM_INV, AM_INV, AM_IMM},
			'{AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS, AM_ABS},
			'{AM_IDY, AM_IDY, AM_IDY, AM_IDY, AM_INV, AM_IDY, AM_IDY, AM_IDY},
			'{AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPX, AM_ZPY, AM_ZPY, AM_ZPX, AM_ZPX},
			'{AM_ABY, AM_ABY, AM_ABY, AM_ABY, AM_INV, AM_INV, AM_ABY, AM_ABY},
			'{AM_ABX, AM_ABX, AM_ABX, AM_ABX, AM_INV, AM_ABY, AM_ABX, AM_ABX}
		}
	};

	// Group 0 mnemonics, indexed [aaa][bbb]
	localparam mnemonic_t MN_CC0 [8][8] = '{
		'{MN_BRK, MN_XNOP, MN_PHP, MN_XNOP, MN_BPL, MN_XNOP, MN_CLC, MN_XNOP},
		'{MN_JSR, MN_BIT, MN_PLP, MN_BIT, MN_BMI, MN_XNOP, MN_SEC, MN_XNOP},
		'{MN_RTI, MN_XNOP, MN_PHA, MN_JMP, MN_BVC, MN_XNOP, MN_CLI, MN_XNOP},
		'{MN_RTS, MN_XNOP, MN_PLA, MN_JMP, MN_BVS, MN_XNOP, MN_SEI, MN_XNOP},
		'{MN_XNOP, MN_STY, MN_DEY, MN_STY, MN_BCC, MN_STY, MN_TYA, MN_STY},
		'{MN_LDY, MN_LDY, MN_TAY, MN_LDY, MN_BCS, MN_LDY, MN_CLV, MN_LDY},
		'{MN_CPY, MN_CPY, MN_INY, MN_CPY, MN_BNE, MN_XNOP, MN_CLD, MN_XNOP},
		'{MN_CPX, MN_CPX, MN_INX, MN_CPX, MN_BEQ, MN_XNOP, MN_SED, MN_XNOP}
	};

	// Group 1 mnemonics, indexed [aaa]
	localparam mnemonic_t MN_CC1 [8] = '{
		MN_ORA, MN_AND, MN_EOR, MN_ADC, MN_STA, MN_LDA, MN_CMP, MN_SBC
	};

	// Group 2 mnemonics, indexed [aaa][bbb]
	localparam mnemonic_t MN_CC2 [8][8] = '{
		'{MN_ASL, MN_ASL, MN_ASL, MN_ASL, MN_ASL, MN_ASL, MN_XNOP, MN_ASL},
		'{MN_ROL, MN_ROL, MN_ROL, MN_ROL, MN_ROL, MN_ROL, MN_XNOP, MN_ROL},
		'{MN_LSR, MN_LSR, MN_LSR, MN_LSR, MN_LSR, MN_LSR, MN_PHY, MN_LSR},
		'{MN_ROR, MN_ROR, MN_ROR, MN_ROR, MN_ROR, MN_ROR, MN_PLY, MN_ROR},
		'{MN_XNOP, MN_STX, MN_TXA, MN_STX, MN_STX, MN_STX, MN_TXS, MN_STX},
		'{MN_LDX, MN_LDX, MN_TAX, MN_LDX, MN_LDA, MN_LDX, MN_TSX, MN_LDX},
		'{MN_XNOP, MN_DEC, MN_DEX, MN_DEC, MN_DEC, MN_DEC, MN_PHX, MN_DEC},
		'{MN_XNOP, MN_INC, MN_NOP, MN_INC, MN_INC, MN_INC, MN_PLX, MN_INC}
	};

	// Group 3 (undocumented) mnemonics, indexed [aaa]; aaa=7 refined by bbb
	localparam mnemonic_t MN_CC3 [8] = '{
		MN_XSLO, MN_XRLA, MN_XSRE, MN_XRRA, MN_XSAX, MN_XLAX, MN_XDCP, MN_XISB
	};

endpackage

[src/cpu65c02_opcode_decoder.sv]
// 65C02 opcode decoder (undocumented opcodes included), top level.
// Depends on c02dec_pkg, c02dec_decode and c02dec_operand.
//
// Takes one instruction per clock while in_stall is low: the PC, the opcode byte
// and the two bytes after it, and returns mnemonic, addressing mode, indirect-JMP
// flag, operand, length, next PC and relative branch target. Throughput is one
// transaction per cycle when the output does not stall. An accepted input is
// held in the input register stage and its result in the result register stage,
// with the table decode and 16-bit adds between them. Both stages hold their
// contents under out_stall, and in_stall rises only when both stages are full
// and the output is stalled.

module cpu65c02_opcode_decoder import c02dec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] pc,
	input  logic [7:0]  opcode,
	input  logic [7:0]  operand_low,
	input  logic [7:0]  operand_high,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  mnemonic,
	output logic [3:0]  addr_mode,
	output logic        is_indirect,
	output logic [15:0] operand_value,
	output logic [1:0]  length,
	output logic [15:0] next_pc,
	output logic [15:0] branch_target
);

	logic        valid_s1;
	logic [15:0] pc_s1;
	logic [7:0]  opcode_s1;
	logic [7:0]  lo_s1;
	logic [7:0]  hi_s1;
	logic        valid_s2;
	res_t        res_s2;
	logic        adv_s1;
	logic        adv_s2;
	dec_t        dec;
	res_t        res;

	// Stage advance: a stage loads when empty or when its content moves on
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			pc_s1     <= pc;
			opcode_s1 <= opcode;
			lo_s1     <= operand_low;
			hi_s1     <= operand_high;
		end
	end

	// Decode logic between the stages
	c02dec_decode u_decode (
		.opcode (opcode_s1),
		.dec    (dec)
	);

	c02dec_operand u_operand (
		.dec          (dec),
		.pc           (pc_s1),
		.operand_low  (lo_s1),
		.operand_high (hi_s1),
		.res          (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	// Output ports
	assign out_valid     = valid_s2;
	assign mnemonic      = res_s2.dec.mnemonic;
	assign addr_mode     = res_s2.dec.mode;
	assign is_indirect   = res_s2.dec.indirect;
	assign operand_value = res_s2.operand;
	assign length        = res_s2.length;
	assign next_pc       = res_s2.next_pc;
	assign branch_target = res_s2.branch_target;

	// Checks
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while a stage is free");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (length != 2'd0))
		else $error("zero instruction length");

	a_target_rel_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res_s2.dec.mode != AM_REL) |-> (branch_target == 16'h0000))
		else $error("branch target outside relative mode");

	a_one_byte_no_operand: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && length == 2'd1) |-> (operand_value == 16'h0000))
		else $error("operand on one-byte instruction");

	a_indirect_is_jmp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_indirect) |-> (res_s2.dec.mnemonic == MN_JMP
			&& res_s2.dec.mode == AM_JMP))
		else $error("indirect flag on non-JMP");

endmodule

[src/c02dec_decode.sv]
// Opcode table decode: mnemonic, addressing mode and indirect-JMP flag.
// Depends on c02dec_pkg for the tables and the dec_t struct.

module c02dec_decode import c02dec_pkg::*; (
	input  logic [7:0] opcode,
	output dec_t       dec
);

	logic [2:0] aaa;
	logic [2:0] bbb;
	logic [1:0] cc;
	mnemonic_t  mn;

	assign aaa = opcode[7:5];
	assign bbb = opcode[4:2];
	assign cc  = opcode[1:0];

	// Mode straight from the table, indirect flag from the opcode fields
	assign dec.mode     = MODE_TAB[cc][bbb][aaa];
	assign dec.indirect = (cc == CC_GROUP0) && (aaa == AAA_JMP) && (bbb == BBB_ABS);
	assign dec.mnemonic = mn;

	// Mnemonic by opcode group
	always_comb begin
		unique case (cc)
			2'd0: begin
				mn = MN_CC0[aaa][bbb];
			end
			2'd1: begin
				// STA #imm does not exist: decodes as a two-byte NOP
				if (aaa == AAA_STA && bbb == BBB_IMM) begin
					mn = MN_XNOP;
				end else begin
					mn = MN_CC1[aaa];
				end
			end
			2'd2: begin
				mn = MN_CC2[aaa][bbb];
			end
			default: begin
				if (aaa == AAA_SBC && bbb == BBB_IMM) begin
					mn = MN_XSBC;
				end else begin
					mn = MN_CC3[aaa];
				end
			end
		endcase
	end

endmodule

[src/c02dec_operand.sv]
// Length, operand assembly, next PC and branch target from the decoded mode.
// Depends on c02dec_pkg for addr_mode_t, dec_t and res_t.

module c02dec_operand import c02dec_pkg::*; (
	input  dec_t        dec,
	input  logic [15:0] pc,
	input  logic [7:0]  operand_low,
	input  logic [7:0]  operand_high,
	output res_t        res
);

	logic [1:0]  len;
	logic [15:0] operand;
	logic        is_rel;
	logic [15:0] offset;

	// Length and operand by mode class
	always_comb begin
		is_rel = 1'b0;
		unique case (dec.mode)
			AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_IDX, AM_IDY, AM_ZPI: begin
				len     = 2'd2;
				operand = {8'h00, operand_low};
			end
			AM_REL: begin
				len     = 2'd2;
				operand = {8'h00, operand_low};
				is_rel  = 1'b1;
			end
			AM_ABS, AM_ABX, AM_ABY, AM_JMP, AM_JSR: begin
				len     = 2'd3;
				operand = {operand_high, operand_low};
			end
			default: begin
				len     = 2'd1;
				operand = 16'h0000;
			end
		endcase
	end

	// Address arithmetic, all modulo 64K
	assign offset = {{8{operand_low[7]}}, operand_low};

	assign res.dec           = dec;
	assign res.operand       = operand;
	assign res.length        = len;
	assign res.next_pc       = pc + {14'd0, len};
	assign res.branch_target = is_rel ? (pc + 16'd2 + offset) : 16'h0000;

endmodule
